>>> rtl/core/tfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types, constants and color expansion for the texel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_ADDR_W    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int IDX_W         = 8;
    localparam int WORD_W        = 32;
    localparam int ENTRIES_W     = 9;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 9;

    typedef enum logic [2:0] {
        MODE_RGBA32 = 3'd0,
        MODE_RGB24  = 3'd1,
        MODE_RGBA16 = 3'd2,
        MODE_IDX8   = 3'd3,
        MODE_IDX4   = 3'd4
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TEXTURE_MODE    = 2'd0,
        CFG_PALETTE_FORMAT  = 2'd1,
        CFG_PALETTE_ENTRIES = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_DIRECT = 2'd1,
        OP_LOOKUP = 2'd2
    } op_kind_t;

    typedef struct packed {
        mode_t                texture_mode;
        logic                 palette_format;
        logic [ENTRIES_W-1:0] palette_entries;
    } cfg_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
        logic              last_of_item;
        logic              image_end;
    } op_t;

    typedef struct packed {
        logic [WORD_W-1:0] rgba;
        logic              last_of_item;
        logic              image_end;
    } pixel_t;

    // 5-5-5-1 to RGBA8888, red in the low byte
    function automatic logic [WORD_W-1:0] expand16(input logic [15:0] p);
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        logic [7:0] a8;
        r8 = {p[4:0], p[4:2]};
        g8 = {p[9:5], p[9:7]};
        b8 = {p[14:10], p[14:12]};
        a8 = {8{p[15]}};
        return {a8, b8, g8, r8};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tfr_issue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_issue
// Input stage: holds one transaction; unless stalled, issues one pixel
// operation per cycle, two for a paired 4-bit index byte (high nibble first).
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_issue
    import tfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic [IDX_W-1:0]  s_palette_index,
    input  wire logic [WORD_W-1:0] s_pixel_word,
    input  wire logic              s_last_pixel,
    input  wire logic              s_odd_tail,
    input  wire logic              adv,
    output logic                   op_valid,
    output op_t                    op
);

    logic              s0_valid_reg;
    logic              phase_reg;
    logic              s0_cmd_reg;
    logic [IDX_W-1:0]  s0_idx_reg;
    logic [WORD_W-1:0] s0_word_reg;
    logic              s0_last_reg;
    logic              s0_tail_reg;

    logic split;
    logic done;
    logic kind_ok;

    always_comb
    begin
        split   = s0_cmd_reg && (cfg.texture_mode == MODE_IDX4) && !s0_tail_reg;
        done    = !split || phase_reg;
        kind_ok = 1'b1;
        op.kind = OP_DIRECT;
        op.idx  = s0_idx_reg;
        op.word = s0_word_reg;
        if (!s0_cmd_reg)
        begin
            op.kind = OP_WRITE;
        end
        else
        begin
            unique case (cfg.texture_mode)
                MODE_RGBA32, MODE_RGB24, MODE_RGBA16:
                begin
                    op.kind = OP_DIRECT;
                end
                MODE_IDX8:
                begin
                    op.kind = OP_LOOKUP;
                    op.idx  = s0_word_reg[7:0];
                end
                MODE_IDX4:
                begin
                    op.kind = OP_LOOKUP;
                    op.idx  = phase_reg ? {4'h0, s0_word_reg[3:0]}
                                        : {4'h0, s0_word_reg[7:4]};
                end
                default:
                begin
                    kind_ok = 1'b0;
                end
            endcase
        end
        op.last_of_item = done;
        op.image_end    = done && s0_last_reg;
        op_valid        = s0_valid_reg && kind_ok;
        s_ready         = !s0_valid_reg || (adv && done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else if (s_valid && s_ready)
        begin
            s0_valid_reg <= 1'b1;
            phase_reg    <= 1'b0;
        end
        else if (adv && s0_valid_reg)
        begin
            if (done)
            begin
                s0_valid_reg <= 1'b0;
                phase_reg    <= 1'b0;
            end
            else
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            s0_cmd_reg  <= s_command;
            s0_idx_reg  <= s_palette_index;
            s0_word_reg <= s_pixel_word;
            s0_last_reg <= s_last_pixel;
            s0_tail_reg <= s_odd_tail;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tfr_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_palette
// Operation stage with the palette memory: writes entries, reads the
// looked-up entry into a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_palette
    import tfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              op_valid,
    input  wire op_t               op,
    output logic                   s1_valid,
    output op_t                    s1_op,
    output logic [WORD_W-1:0]      rdata
);

    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [WORD_W-1:0] rdata_reg;
    logic [WORD_W-1:0] mem [PALETTE_DEPTH];

    logic                  slot_ok;
    logic                  wr_en;
    logic [PAL_ADDR_W-1:0] addr;

    always_comb
    begin
        slot_ok = ({1'b0, s1_op_reg.idx} < ENTRIES_W'(PALETTE_DEPTH));
        wr_en   = s1_valid_reg && (s1_op_reg.kind == OP_WRITE) && slot_ok;
        addr    = s1_op_reg.idx[PAL_ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (wr_en)
            begin
                mem[addr] <= s1_op_reg.word;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_op    = s1_op_reg;
    assign rdata    = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/tfr_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_color
// Color stage: converts direct texels, range-checks lookups, then expands
// the palette entry in 16-bit format and selects the final RGBA8888 pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_color
    import tfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              adv,
    input  wire logic              s1_valid,
    input  wire op_t               s1_op,
    input  wire logic [WORD_W-1:0] rdata,
    output logic                   px_valid,
    output pixel_t                 px
);

    logic              s2_valid_reg;
    logic              s2_lookup_reg;
    logic              s2_hit_reg;
    logic [WORD_W-1:0] s2_direct_reg;
    logic              s2_last_reg;
    logic              s2_end_reg;

    logic [WORD_W-1:0] direct;
    logic              hit;
    logic [WORD_W-1:0] entry;

    always_comb
    begin
        unique case (cfg.texture_mode)
            MODE_RGB24:  direct = {8'hFF, s1_op.word[23:0]};
            MODE_RGBA16: direct = expand16(s1_op.word[15:0]);
            default:     direct = s1_op.word;
        endcase
        hit = ({1'b0, s1_op.idx} < cfg.palette_entries)
           && ({1'b0, s1_op.idx} < ENTRIES_W'(PALETTE_DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid && (s1_op.kind != OP_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_lookup_reg <= (s1_op.kind == OP_LOOKUP);
            s2_hit_reg    <= hit;
            s2_direct_reg <= direct;
            s2_last_reg   <= s1_op.last_of_item;
            s2_end_reg    <= s1_op.image_end;
        end
    end

    always_comb
    begin
        entry = cfg.palette_format ? expand16(rdata[15:0]) : rdata;
        if (!s2_lookup_reg)
        begin
            px.rgba = s2_direct_reg;
        end
        else if (s2_hit_reg)
        begin
            px.rgba = entry;
        end
        else
        begin
            px.rgba = '0;
        end
        px.last_of_item = s2_last_reg;
        px.image_end    = s2_end_reg;
        px_valid        = s2_valid_reg;
    end

endmodule

`default_nettype wire

>>> rtl/core/tfr_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_out_skid
// Output register with a skid entry; the pipeline advance is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_out_skid
    import tfr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire pixel_t in_px,
    output logic        adv,
    output logic        m_valid,
    input  wire logic   m_ready,
    output pixel_t      m_px
);

    logic   out_valid_reg;
    pixel_t out_reg;
    logic   skid_valid_reg;
    pixel_t skid_reg;
    logic   push;
    logic   drain;

    assign adv   = !skid_valid_reg;
    assign push  = in_valid && !skid_valid_reg;
    assign drain = !out_valid_reg || m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= in_px;
            end
        end
        else if (push)
        begin
            skid_reg <= in_px;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_px    = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/texel_format_to_rgba_with_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_format_to_rgba_with_palette
// Texel stream to RGBA8888 converter with a 256-entry color palette.
//
// s_axis carries commands: tuser[0] selects palette write (0) or convert (1),
// tdata holds the palette slot and the texel word. A palette write stores a
// raw entry and gives no output. A convert in a valid texture mode gives one
// RGBA pixel on m_axis, or two for a 4-bit index byte without tuser[1] set.
// The cfg port sets the texture mode, palette format and number of valid
// palette entries; write it only while the block is idle.
// A transaction passes the issue, palette, color and output registers on
// its way to m_axis; the second pixel of a 4-bit pair follows the first.
// Throughput: with m_axis ready, one transaction per cycle; a paired 4-bit
// byte issues both nibble pixels before s_axis takes the next transaction.
// Reset clears the pipeline and the configuration; palette contents stay
// unknown until written. When m_axis stalls, a skid entry takes the pixel
// in flight, the pipeline then holds, and s_axis tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module texel_format_to_rgba_with_palette
    import tfr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [39:0]           s_axis_tdata,   // palette_index, pixel_word
    input  wire logic                  s_axis_tlast,
    input  wire logic [1:0]            s_axis_tuser,   // command, odd_tail
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [31:0]                m_axis_tdata,   // red, green, blue, alpha
    output logic                       m_axis_tlast,
    output logic                       m_axis_tuser,   // last_of_item
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t              cfg_reg;
    logic              adv;
    logic              op_valid;
    op_t               op;
    logic              s1_valid;
    op_t               s1_op;
    logic [WORD_W-1:0] rdata;
    logic              px_valid;
    pixel_t            px;
    pixel_t            m_px;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{texture_mode: MODE_RGBA32, palette_format: 1'b0,
                         palette_entries: '0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_TEXTURE_MODE:    cfg_reg.texture_mode    <= mode_t'(cfg_wdata[2:0]);
                CFG_PALETTE_FORMAT:  cfg_reg.palette_format  <= cfg_wdata[0];
                CFG_PALETTE_ENTRIES: cfg_reg.palette_entries <= cfg_wdata[ENTRIES_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tfr_issue u_issue (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .s_valid         (s_axis_tvalid),
        .s_ready         (s_axis_tready),
        .s_command       (s_axis_tuser[0]),
        .s_palette_index (s_axis_tdata[7:0]),
        .s_pixel_word    (s_axis_tdata[39:8]),
        .s_last_pixel    (s_axis_tlast),
        .s_odd_tail      (s_axis_tuser[1]),
        .adv             (adv),
        .op_valid        (op_valid),
        .op              (op)
    );

    tfr_palette u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .op_valid (op_valid),
        .op       (op),
        .s1_valid (s1_valid),
        .s1_op    (s1_op),
        .rdata    (rdata)
    );

    tfr_color u_color (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .adv      (adv),
        .s1_valid (s1_valid),
        .s1_op    (s1_op),
        .rdata    (rdata),
        .px_valid (px_valid),
        .px       (px)
    );

    tfr_out_skid u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (px_valid),
        .in_px    (px),
        .adv      (adv),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_px     (m_px)
    );

    assign m_axis_tdata = m_px.rgba;
    assign m_axis_tlast = m_px.image_end;
    assign m_axis_tuser = m_px.last_of_item;

    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> !m_axis_tlast)
        else $error("image end flagged on the first pixel of a pair");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tuser) |=> m_axis_tvalid)
        else $error("second pixel of a pair did not follow");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (px_valid && !adv) |=> px_valid)
        else $error("pixel lost in color stage during stall");

endmodule

`default_nettype wire

>>> tb/texel_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_tb_pkg
// Command codes shared by the texel converter stimulus and its checker.
// ----------------------------------------------------------------------------

package texel_tb_pkg;

    localparam logic CMD_PALETTE_WRITE = 1'b0;
    localparam logic CMD_CONVERT       = 1'b1;

endpackage

>>> tb/rgba_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_pixel_checker
// Watches the command, pixel and register ports of the texel converter.
// Keeps its own palette and register copies, works out the RGBA pixels each
// accepted command should give, and compares every accepted pixel in order.
// ----------------------------------------------------------------------------

module rgba_pixel_checker
    import tfr_pkg::*;
    import texel_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,   // palette_index, pixel_word
    input  logic                  s_axis_tlast,
    input  logic [1:0]            s_axis_tuser,   // command, odd_tail
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [31:0]           m_axis_tdata,   // red, green, blue, alpha
    input  logic                  m_axis_tlast,
    input  logic                  m_axis_tuser,   // last_of_item
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    error_count,
    output int                    pending
);

    typedef struct packed {
        logic [31:0] rgba;
        logic        last_of_item;
        logic        image_end;
    } rgba_pixel_t;

    rgba_pixel_t          expected_pixels[$];
    logic [31:0]          palette_copy[PALETTE_DEPTH];
    logic [2:0]           mode_copy;
    logic                 fmt_copy;
    logic [ENTRIES_W-1:0] entries_copy;

    initial
    begin
        error_count = 0;
        pending     = 0;
    end

    function automatic logic [31:0] widen_5551(input logic [15:0] p);
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        r = p[4:0];
        g = p[9:5];
        b = p[14:10];
        return {p[15] ? 8'hFF : 8'h00, b, b[4:2], g, g[4:2], r, r[4:2]};
    endfunction

    function automatic logic [31:0] palette_color(input logic [7:0] idx);
        logic [31:0] raw;
        raw = palette_copy[idx];
        if ({1'b0, idx} >= entries_copy)
        begin
            return 32'h0;
        end
        return fmt_copy ? widen_5551(raw[15:0]) : raw;
    endfunction

    task automatic push_pixel(input logic [31:0] rgba, input logic last_item,
                              input logic img_end);
        rgba_pixel_t px;
        px.rgba         = rgba;
        px.last_of_item = last_item;
        px.image_end    = img_end;
        expected_pixels.push_back(px);
    endtask

    task automatic predict_texel(input logic cmd, input logic [7:0] slot,
                                 input logic [31:0] word, input logic last,
                                 input logic tail);
        if (cmd == CMD_PALETTE_WRITE)
        begin
            palette_copy[slot] = word;
            return;
        end
        case (mode_copy)
            MODE_RGBA32: push_pixel(word, 1'b1, last);
            MODE_RGB24:  push_pixel({8'hFF, word[23:0]}, 1'b1, last);
            MODE_RGBA16: push_pixel(widen_5551(word[15:0]), 1'b1, last);
            MODE_IDX8:   push_pixel(palette_color(word[7:0]), 1'b1, last);
            MODE_IDX4:
            begin
                if (tail)
                begin
                    push_pixel(palette_color({4'h0, word[7:4]}), 1'b1, last);
                end
                else
                begin
                    push_pixel(palette_color({4'h0, word[7:4]}), 1'b0, 1'b0);
                    push_pixel(palette_color({4'h0, word[3:0]}), 1'b1, last);
                end
            end
            default: ;
        endcase
    endtask

    task automatic log_error(input string what);
        error_count++;
        if (error_count <= 10)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    always @(posedge clk)
    begin : watch
        rgba_pixel_t want;
        if (!rst_n)
        begin
            mode_copy    = MODE_RGBA32;
            fmt_copy     = 1'b0;
            entries_copy = '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    log_error($sformatf("unexpected pixel rgba %h last_of_item %b image_end %b",
                                        m_axis_tdata, m_axis_tuser, m_axis_tlast));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata !== want.rgba || m_axis_tuser !== want.last_of_item
                        || m_axis_tlast !== want.image_end)
                    begin
                        log_error($sformatf({"pixel mismatch: expected rgba %h last_of_item %b",
                                             " image_end %b, got rgba %h last_of_item %b",
                                             " image_end %b"},
                                            want.rgba, want.last_of_item, want.image_end,
                                            m_axis_tdata, m_axis_tuser, m_axis_tlast));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_texel(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[39:8],
                              s_axis_tlast, s_axis_tuser[1]);
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    CFG_TEXTURE_MODE:    mode_copy    = cfg_wdata[2:0];
                    CFG_PALETTE_FORMAT:  fmt_copy     = cfg_wdata[0];
                    CFG_PALETTE_ENTRIES: entries_copy = cfg_wdata[ENTRIES_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_pixels.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the texel converter through every texture mode and palette setting.
// A short directed pass covers extremes and corner cases, then random phases
// mix palette writes with texel conversions under random source and sink
// stalls. A separate checker predicts and compares each output pixel.
// ----------------------------------------------------------------------------

module testbench;

    import tfr_pkg::*;
    import texel_tb_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int IDLE_LIMIT  = 1000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata  = '0;   // palette_index, pixel_word
    logic                  s_axis_tlast  = 1'b0;
    logic [1:0]            s_axis_tuser  = '0;   // command, odd_tail
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [31:0]           m_axis_tdata;         // red, green, blue, alpha
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;         // last_of_item
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    int   error_count;
    int   pending;
    int   items_sent = 0;
    int   idle_cycles = 0;
    int   ready_hold = 0;
    int   send_left = 0;
    bit   send_calm = 1'b0;
    int   sink_left = 0;
    bit   sink_calm = 1'b0;
    logic [2:0] cur_mode = MODE_RGBA32;
    int   cur_entries = 0;
    bit   slot_written[PALETTE_DEPTH];

    always #5 clk = ~clk;

    texel_format_to_rgba_with_palette i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    rgba_pixel_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .error_count   (error_count),
        .pending       (pending)
    );

    function automatic int draw_gap(inout int stretch_left, inout bit calm);
        if (stretch_left == 0)
        begin
            calm         = ($urandom_range(0, 3) == 0);
            stretch_left = $urandom_range(10, 60);
        end
        stretch_left--;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // sink side: after each transaction drop tready for a random gap, which may be zero
    always @(posedge clk)
    begin : sink_stall
        int g;
        if (m_axis_tready && m_axis_tvalid)
        begin
            g = draw_gap(sink_left, sink_calm);
            m_axis_tready <= (g == 0);
            ready_hold    <= g;
        end
        else if (!m_axis_tready)
        begin
            if (ready_hold <= 1)
            begin
                m_axis_tready <= 1'b1;
            end
            ready_hold <= (ready_hold > 0) ? ready_hold - 1 : 0;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] slot,
                             input logic [31:0] word, input logic last, input logic tail);
        int gap;
        gap = draw_gap(send_left, send_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {word, slot};
        s_axis_tlast  <= last;
        s_axis_tuser  <= {tail, cmd};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_palette(input int slot, input logic [31:0] word);
        send_item(CMD_PALETTE_WRITE, slot[7:0], word, 1'($urandom), 1'($urandom));
        slot_written[slot] = 1'b1;
    endtask

    // write a slot before any in-range lookup could read it unwritten
    task automatic prime_slot(input int idx);
        int eff;
        eff = (cur_entries > PALETTE_DEPTH) ? PALETTE_DEPTH : cur_entries;
        if (idx < eff && !slot_written[idx])
        begin
            send_palette(idx, $urandom);
        end
    endtask

    task automatic send_texel(input logic [31:0] word, input logic last, input logic tail);
        if (cur_mode == MODE_IDX8)
        begin
            prime_slot(word[7:0]);
        end
        else if (cur_mode == MODE_IDX4)
        begin
            prime_slot(word[7:4]);
            if (!tail)
            begin
                prime_slot(word[3:0]);
            end
        end
        send_item(CMD_CONVERT, 8'($urandom), word, last, tail);
    endtask

    // drop valid and wait until the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] mode, input logic fmt, input int entries);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TEXTURE_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_addr  <= CFG_PALETTE_FORMAT;
        cfg_wdata <= CFG_DATA_W'(fmt);
        @(posedge clk);
        cfg_addr  <= CFG_PALETTE_ENTRIES;
        cfg_wdata <= CFG_DATA_W'(entries);
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_mode    = mode;
        cur_entries = entries;
    endtask

    task automatic random_phase();
        logic [2:0]  mode;
        logic [31:0] word;
        int          entries;
        int          len;
        int          eff;
        int          pick;
        pick = $urandom_range(0, 19);
        mode = (pick == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        case ($urandom_range(0, 9))
            0:       entries = 0;
            1:       entries = 1;
            2:       entries = 16;
            3:       entries = 256;
            4:       entries = $urandom_range(257, 511);
            5:       entries = 15;
            default: entries = $urandom_range(0, 256);
        endcase
        configure(mode, 1'($urandom), entries);
        len = (pick == 0) ? 5 : $urandom_range(30, 120);
        eff = (entries > PALETTE_DEPTH) ? PALETTE_DEPTH : entries;
        repeat (len)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                send_palette($urandom_range(0, 255), $urandom);
            end
            else
            begin
                word = $urandom;
                if (cur_mode == MODE_IDX8 && eff > 0 && $urandom_range(0, 9) != 0)
                begin
                    word[7:0] = 8'($urandom_range(0, eff - 1));
                end
                send_texel(word, ($urandom_range(0, 7) == 0), 1'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_texel(32'h0000_0000, 1'b0, 1'b0);
        send_texel(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_texel(32'h8040_2010, 1'b0, 1'b1);

        configure(MODE_RGB24, 1'b0, 0);
        send_texel(32'h1234_5678, 1'b0, 1'b0);
        send_texel(32'h00FF_FFFF, 1'b1, 1'b0);

        configure(MODE_RGBA16, 1'b0, 0);
        send_texel(32'h0000_0000, 1'b0, 1'b0);
        send_texel(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_texel(32'h0000_8000, 1'b0, 1'b0);
        send_texel(32'hABCD_7FFF, 1'b1, 1'b0);

        configure(MODE_IDX8, 1'b0, 0);
        send_texel(32'h0000_0000, 1'b0, 1'b0);
        send_texel(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_palette(0, 32'hDEAD_BEEF);
        send_palette(255, 32'h0123_4567);

        configure(MODE_IDX8, 1'b0, 256);
        send_texel(32'h0000_0000, 1'b0, 1'b0);
        send_texel(32'h0000_00FF, 1'b1, 1'b0);

        configure(MODE_IDX8, 1'b1, 255);
        send_texel(32'h0000_00FF, 1'b0, 1'b0);
        send_texel(32'hFFFF_FF00, 1'b1, 1'b0);

        configure(MODE_IDX4, 1'b1, 16);
        send_texel(32'h0000_00F0, 1'b0, 1'b0);
        send_texel(32'h0000_000F, 1'b1, 1'b1);
        send_texel(32'h0000_00F0, 1'b1, 1'b0);

        configure(MODE_IDX4, 1'b0, 511);
        send_texel(32'h0000_00FF, 1'b1, 1'b0);

        configure(3'd7, 1'b1, 256);
        send_texel($urandom, 1'b1, 1'b0);
        send_texel($urandom, 1'b0, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            random_phase();
        end

        settle();
        if (error_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tfr_pkg.sv
rtl/core/tfr_issue.sv
rtl/core/tfr_palette.sv
rtl/core/tfr_color.sv
rtl/core/tfr_out_skid.sv
rtl/core/texel_format_to_rgba_with_palette.sv
tb/texel_tb_pkg.sv
tb/rgba_pixel_checker.sv
tb/testbench.sv
